>>> sv/mds_pkg.sv
// package for the motor drive supervisor: widths, action and error codes, states
// no dependencies
`timescale 1ns / 1ps

package mds_pkg;

	localparam int TIME_BITS = 32;
	localparam int SPD_W     = 16;
	localparam int CFG_W     = 16;
	localparam int IDX_W     = 3;

	typedef enum logic [2:0] {
		ACT_INIT    = 3'd0,
		ACT_START   = 3'd1,
		ACT_SET     = 3'd2,
		ACT_DROP    = 3'd3,
		ACT_SERVICE = 3'd4,
		ACT_TICK    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_STALE    = 2'd1,
		ERR_LINK     = 2'd2,
		ERR_WATCHDOG = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CMD_LIMIT   = 3'd0,
		REG_START_LIMIT = 3'd1,
		REG_RAMP_STAGE  = 3'd2,
		REG_MAX_AGE     = 3'd3,
		REG_WATCHDOG    = 3'd4,
		REG_SEND_PERIOD = 3'd5,
		REG_REV_PAUSE   = 3'd6,
		REG_SLEW_STEP   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SHAPE,
		ST_ISSUE,
		ST_OUT
	} state_t;

	// direction of a signed command
	function automatic dir_t dir_of(input logic signed [SPD_W-1:0] v);
		dir_t d;
		d = DIR_NONE;
		if (v > 0) d = DIR_FWD;
		else if (v < 0) d = DIR_REV;
		return d;
	endfunction

	// clamp magnitude to a positive 16-bit limit
	function automatic logic signed [SPD_W-1:0] clamp_mag(input logic signed [SPD_W:0] v,
			input logic [SPD_W-1:0] lim);
		logic signed [SPD_W:0] l;
		logic signed [SPD_W-1:0] r;
		l = $signed({1'b0, lim});
		r = v[SPD_W-1:0];
		if (v > l) r = l[SPD_W-1:0];
		else if (v < -l) r = -l[SPD_W-1:0];
		return r;
	endfunction

endpackage

>>> sv/motor_drive_supervisor_top.sv
// top level of the two-wheel drive supervisor
// depends on mds_pkg and mds_div
`timescale 1ns / 1ps
// Usage:
//  input channel in_valid/in_ready carries one action per transfer; the
//  output channel out_valid/out_ready returns exactly one status item each.
//  Configuration is to be written through cfg_we/cfg_index/cfg_data only
//  while idle; the block does not enforce this. Actions other than service
//  raise out_valid on entry to the output state, after the multiply state.
//  A service step with a valid fresh target inside the ramp runs the ramp
//  limit through a shared 16 by 15-bit multiplier and then a bit-serial
//  divider, one quotient bit per cycle, then the shape and issue states; one
//  past the ramp skips the divider and other service steps skip the shape
//  state too. One item is worked on at a time: in_ready is low from
//  acceptance until, after the result has been transferred, the output
//  state returns to idle. If the receiver stalls, the result waits in the
//  output register and no new item is taken. Reset clears all state but
//  the divider datapath and loads the register defaults; no clearing pass.

module motor_drive_supervisor_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       action,
	input  logic signed [15:0]               left_setpoint,
	input  logic signed [15:0]               right_setpoint,
	input  logic [mds_pkg::TIME_BITS-1:0]    request_time,
	input  logic [mds_pkg::TIME_BITS-1:0]    now_time,
	input  logic                             link_ok,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             frame_valid,
	output logic signed [15:0]               left_cmd,
	output logic signed [15:0]               right_cmd,
	output logic                             emergency_stop,
	output logic                             started_flag,
	output logic                             fault_flag,
	output logic [1:0]                       error_code,
	output logic signed [15:0]               left_target,
	output logic signed [15:0]               right_target,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [mds_pkg::CFG_W-1:0]        cfg_data
);

	localparam int TB = mds_pkg::TIME_BITS;

	// configuration registers
	logic [14:0] cmd_limit_q, start_limit_q, ramp_stage_q, rev_pause_q, slew_step_q;
	logic [15:0] max_age_q, watchdog_q, send_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_limit_q   <= 15'd1000;
			start_limit_q <= 15'd135;
			ramp_stage_q  <= 15'd1000;
			max_age_q     <= 16'd50;
			watchdog_q    <= 16'd200;
			send_period_q <= 16'd5;
			rev_pause_q   <= 15'd120;
			slew_step_q   <= 15'd3;
		end else if (cfg_we) begin
			case (mds_pkg::reg_idx_t'(cfg_index))
				mds_pkg::REG_CMD_LIMIT:   cmd_limit_q   <= cfg_data[14:0];
				mds_pkg::REG_START_LIMIT: start_limit_q <= cfg_data[14:0];
				mds_pkg::REG_RAMP_STAGE:  ramp_stage_q  <= cfg_data[14:0];
				mds_pkg::REG_MAX_AGE:     max_age_q     <= cfg_data;
				mds_pkg::REG_WATCHDOG:    watchdog_q    <= cfg_data;
				mds_pkg::REG_SEND_PERIOD: send_period_q <= cfg_data;
				mds_pkg::REG_REV_PAUSE:   rev_pause_q   <= cfg_data[14:0];
				mds_pkg::REG_SLEW_STEP:   slew_step_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// supervisor state
	logic               started_q, faulted_q, tvalid_q;
	logic [1:0]         err_q;
	logic signed [15:0] tgt_q [2];
	logic signed [15:0] app_q [2];
	logic [TB-1:0]      tstamp_q, last_send_q;
	logic [15:0]        ramp_q, wd_q;
	mds_pkg::dir_t      ldir_q [2];
	logic [15:0]        zc_q [2];

	// captured item
	logic [2:0]         act_q;
	logic signed [15:0] ls_q, rs_q;
	logic [TB-1:0]      rt_q, now_q;
	logic               ok_q;

	mds_pkg::state_t state_q, state_d;

	// sequencing scratch
	logic [31:0]        prod_q;
	logic [15:0]        base_q;
	logic signed [15:0] lim_q;
	logic signed [15:0] want_q [2];

	// output register
	logic               ov_q;

	// derived values
	logic [14:0] stage;
	logic [14:0] st_eff;
	logic [15:0] stage2;
	always_comb begin
		stage  = (ramp_stage_q == 15'd0) ? 15'd1 : ramp_stage_q;
		st_eff = (start_limit_q > cmd_limit_q) ? cmd_limit_q : start_limit_q;
		stage2 = {stage, 1'b0};
	end

	// watchdog count reaches or has already reached its limit on this tick
	logic wd_trip;
	always_comb begin
		wd_trip = (wd_q + 17'd1 >= 17'(watchdog_q) && (wd_q < watchdog_q))
			|| wd_q >= watchdog_q;
	end

	// ramp phase decode
	logic        ph_first, ph_second;
	logic [15:0] mul_a;
	logic [14:0] mul_b;
	always_comb begin
		ph_first  = ramp_q <= {1'b0, stage};
		ph_second = !ph_first && (ramp_q < stage2);
		if (ph_first) begin
			mul_a = ramp_q;
			mul_b = st_eff;
		end else begin
			mul_a = ramp_q - {1'b0, stage};
			mul_b = cmd_limit_q - st_eff;
		end
	end

	// kick the divider on the first cycle in the divide state
	logic div_kick_q;
	logic div_go;
	assign div_go = div_kick_q;

	// shared divider
	logic        div_done;
	logic [31:0] div_quo;
	mds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (prod_q),
		.divisor  (stage),
		.done     (div_done),
		.quotient (div_quo)
	);

	// service check
	logic [TB-1:0] age, since;
	logic          service_ok;
	always_comb begin
		age        = now_q - tstamp_q;
		since      = now_q - last_send_q;
		service_ok = started_q && !faulted_q && tvalid_q && (age <= TB'(max_age_q));
	end

	// interlock per wheel
	logic signed [15:0] lck [2];
	always_comb begin
		for (int w = 0; w < 2; w++) begin
			mds_pkg::dir_t d;
			d = mds_pkg::dir_of(want_q[w]);
			lck[w] = want_q[w];
			if (d != mds_pkg::DIR_NONE && ldir_q[w] != mds_pkg::DIR_NONE && d != ldir_q[w]
					&& !(zc_q[w] > {1'b0, rev_pause_q}))
				lck[w] = '0;
		end
	end

	// frame decision with slew
	logic               imm, send;
	logic signed [15:0] fcmd [2];
	always_comb begin
		imm  = (lck[0] == 0 && app_q[0] != 0) || (lck[1] == 0 && app_q[1] != 0);
		send = imm || !(since < TB'(send_period_q));
		for (int w = 0; w < 2; w++) begin
			logic signed [17:0] hi, lo, wv;
			hi = 18'(app_q[w]) + $signed({3'b0, slew_step_q});
			lo = 18'(app_q[w]) - $signed({3'b0, slew_step_q});
			wv = 18'(lck[w]);
			fcmd[w] = lck[w];
			if (!imm) begin
				if (wv > hi) fcmd[w] = hi[15:0];
				else if (wv < lo) fcmd[w] = lo[15:0];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mds_pkg::ST_IDLE:  if (in_valid) state_d = mds_pkg::ST_MUL;
			mds_pkg::ST_MUL: begin
				if (mds_pkg::action_t'(act_q) == mds_pkg::ACT_SERVICE) begin
					if (service_ok && (ph_first || ph_second)) state_d = mds_pkg::ST_DIV;
					else if (service_ok) state_d = mds_pkg::ST_SHAPE;
					else state_d = mds_pkg::ST_ISSUE;
				end else state_d = mds_pkg::ST_OUT;
			end
			mds_pkg::ST_DIV: begin
				if (div_done) state_d = mds_pkg::ST_SHAPE;
			end
			mds_pkg::ST_SHAPE: state_d = mds_pkg::ST_ISSUE;
			mds_pkg::ST_ISSUE: state_d = mds_pkg::ST_OUT;
			mds_pkg::ST_OUT:   if (!ov_q) state_d = mds_pkg::ST_IDLE;
			default:           state_d = mds_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_kick_q <= 1'b0;
		else div_kick_q <= (state_q == mds_pkg::ST_MUL) && (state_d == mds_pkg::ST_DIV);
	end

	assign in_ready = (state_q == mds_pkg::ST_IDLE);

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mds_pkg::ST_IDLE;
			started_q   <= 1'b0;
			faulted_q   <= 1'b0;
			tvalid_q    <= 1'b0;
			err_q       <= mds_pkg::ERR_NONE;
			tstamp_q    <= '0;
			last_send_q <= '0;
			ramp_q      <= '0;
			wd_q        <= '0;
			ov_q        <= 1'b0;
			act_q       <= '0;
			ls_q        <= '0;
			rs_q        <= '0;
			rt_q        <= '0;
			now_q       <= '0;
			ok_q        <= 1'b0;
			prod_q      <= '0;
			base_q      <= '0;
			lim_q       <= '0;
			frame_valid <= 1'b0;
			emergency_stop <= 1'b0;
			left_cmd    <= '0;
			right_cmd   <= '0;
			left_target  <= '0;
			right_target <= '0;
			for (int w = 0; w < 2; w++) begin
				tgt_q[w]  <= '0;
				app_q[w]  <= '0;
				ldir_q[w] <= mds_pkg::DIR_NONE;
				zc_q[w]   <= '0;
				want_q[w] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				mds_pkg::ST_IDLE: begin
					if (in_valid) begin
						act_q <= action;
						ls_q  <= left_setpoint;
						rs_q  <= right_setpoint;
						rt_q  <= request_time;
						now_q <= now_time;
						ok_q  <= link_ok;
					end
				end
				mds_pkg::ST_MUL: begin
					frame_valid    <= 1'b0;
					emergency_stop <= (mds_pkg::action_t'(act_q) == mds_pkg::ACT_INIT)
						|| ((mds_pkg::action_t'(act_q) == mds_pkg::ACT_TICK)
							&& started_q && !faulted_q && wd_trip);
					left_cmd       <= '0;
					right_cmd      <= '0;
					prod_q <= mul_a * {17'd0, mul_b};
					base_q <= ph_first ? 16'd0 : {1'b0, st_eff};
					lim_q  <= $signed({1'b0, cmd_limit_q});
					want_q[0] <= '0;
					want_q[1] <= '0;
					case (mds_pkg::action_t'(act_q))
						mds_pkg::ACT_INIT: begin
							started_q <= 1'b0;
							faulted_q <= !ok_q;
							tvalid_q  <= 1'b0;
							err_q     <= ok_q ? mds_pkg::ERR_NONE : mds_pkg::ERR_LINK;
							tstamp_q  <= '0;
							last_send_q <= '0;
							ramp_q <= '0;
							wd_q   <= '0;
							left_target  <= '0;
							right_target <= '0;
							for (int w = 0; w < 2; w++) begin
								tgt_q[w]  <= '0;
								app_q[w]  <= '0;
								ldir_q[w] <= mds_pkg::DIR_NONE;
								zc_q[w]   <= '0;
							end
						end
						mds_pkg::ACT_START: if (!faulted_q) begin
							started_q <= 1'b1;
							ramp_q <= '0;
							wd_q   <= '0;
						end
						mds_pkg::ACT_SET: if (started_q && !faulted_q) begin
							tvalid_q <= 1'b1;
							tgt_q[0] <= mds_pkg::clamp_mag(17'(ls_q), {1'b0, cmd_limit_q});
							tgt_q[1] <= mds_pkg::clamp_mag(17'(rs_q), {1'b0, cmd_limit_q});
							left_target  <=
								mds_pkg::clamp_mag(17'(ls_q), {1'b0, cmd_limit_q});
							right_target <=
								mds_pkg::clamp_mag(17'(rs_q), {1'b0, cmd_limit_q});
							tstamp_q <= rt_q;
							wd_q <= '0;
						end
						mds_pkg::ACT_DROP: if (started_q && !faulted_q) tvalid_q <= 1'b0;
						mds_pkg::ACT_SERVICE: begin
							if (started_q && !faulted_q) begin
								err_q <= service_ok ? mds_pkg::ERR_NONE : mds_pkg::ERR_STALE;
							end
						end
						mds_pkg::ACT_TICK: if (started_q && !faulted_q) begin
							if (ramp_q < stage2) ramp_q <= ramp_q + 16'd1;
							if (wd_q < watchdog_q) wd_q <= wd_q + 16'd1;
							for (int w = 0; w < 2; w++) begin
								if (app_q[w] == 0 && ldir_q[w] != mds_pkg::DIR_NONE
										&& zc_q[w] <= {1'b0, rev_pause_q})
									zc_q[w] <= zc_q[w] + 16'd1;
							end
							if (wd_trip) begin
								faulted_q <= 1'b1;
								err_q     <= mds_pkg::ERR_WATCHDOG;
								app_q[0]  <= '0;
								app_q[1]  <= '0;
							end
						end
						default: ;
					endcase
				end
				mds_pkg::ST_DIV: if (div_done) begin
					lim_q <= $signed(16'(base_q + div_quo[15:0]));
				end
				mds_pkg::ST_SHAPE: begin
					want_q[0] <= mds_pkg::clamp_mag(17'(tgt_q[0]), lim_q);
					want_q[1] <= mds_pkg::clamp_mag(17'(tgt_q[1]), lim_q);
				end
				mds_pkg::ST_ISSUE: begin
					if (send) begin
						frame_valid <= 1'b1;
						left_cmd    <= fcmd[0];
						right_cmd   <= fcmd[1];
						if (!ok_q) begin
							faulted_q <= 1'b1;
							err_q     <= mds_pkg::ERR_LINK;
							app_q[0]  <= '0;
							app_q[1]  <= '0;
							emergency_stop <= 1'b1;
						end else begin
							app_q[0] <= fcmd[0];
							app_q[1] <= fcmd[1];
							last_send_q <= now_q;
							for (int w = 0; w < 2; w++) begin
								if (mds_pkg::dir_of(fcmd[w]) != mds_pkg::DIR_NONE) begin
									ldir_q[w] <= mds_pkg::dir_of(fcmd[w]);
									zc_q[w]   <= '0;
								end
							end
						end
					end
				end
				mds_pkg::ST_OUT: ;
				default: ;
			endcase
			// raise result on entry to the output state
			if (state_q != mds_pkg::ST_OUT && state_d == mds_pkg::ST_OUT) ov_q <= 1'b1;
		end
	end

	assign out_valid    = ov_q;
	assign started_flag = started_q;
	assign fault_flag   = faulted_q;
	assign error_code   = err_q;

endmodule

>>> sv/mds_div.sv
// shared restoring divider: one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module mds_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [14:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [15:0] trial;
	logic [16:0] diff;

	// shift in next bit and try subtraction
	assign trial = {rem_q[14:0], quo_q[31]};
	assign diff  = {1'b0, trial} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

>>> sv/mds_checker.sv
// port-level checker for the drive supervisor, bound to the top level
// depends on mds_pkg and motor_drive_supervisor_top
`timescale 1ns / 1ps

module mds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        frame_valid,
	input logic        emergency_stop,
	input logic        fault_flag,
	input logic [1:0]  error_code
);

	// no new transfer while a result is pending
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");

	// no result is pending right after an input transfer
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

	// a latched fault carries a link or watchdog code while a result is pending
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault_flag) |-> (error_code != mds_pkg::ERR_NONE
			&& error_code != mds_pkg::ERR_STALE))
		else $error("fault without link or watchdog code");

	// a frame with a stop only comes from a failed link
	a_frame_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_valid && emergency_stop)
			|-> (fault_flag && error_code == mds_pkg::ERR_LINK))
		else $error("frame with stop but no link fault");

	// a result stays until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind motor_drive_supervisor_top mds_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.frame_valid    (frame_valid),
	.emergency_stop (emergency_stop),
	.fault_flag     (fault_flag),
	.error_code     (error_code)
);
